// ----- sv/mqm_pkg.sv -----
package mqm_pkg;

    // sizing
    localparam int QUEUE_DEPTH  = 16;
    localparam int REGION_COUNT = 9;
    localparam int PAYLOAD_BITS = 64;

    localparam int QUEUE_COUNT = REGION_COUNT + 1;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int QID_W       = $clog2(QUEUE_COUNT);
    localparam int SLOT_DEPTH  = QUEUE_COUNT * QUEUE_DEPTH;
    localparam int SLOT_AW     = $clog2(SLOT_DEPTH);

    // field widths
    localparam int CMD_W    = 2;
    localparam int TARGET_W = 4;
    localparam int WORD_W   = 64;
    localparam int MAXC_W   = 5;
    localparam int COUNT_W  = 5;

    localparam int MAX_POP   = 16;
    localparam int COUNT_MAX = 31;

    localparam int S_TDATA_BITS = TARGET_W + WORD_W + MAXC_W;
    localparam int S_TDATA_W    = ((S_TDATA_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = COUNT_W + WORD_W;
    localparam int M_TDATA_W    = ((M_TDATA_BITS + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_SEND  = 2'd0,
        CMD_RECV  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // per-queue ring descriptor
    typedef struct packed {
        logic [PTR_W-1:0]  head;
        logic [PTR_W-1:0]  tail;
        logic [FILL_W-1:0] fill;
    } desc_t;

    localparam int DESC_W = $bits(desc_t);

    typedef struct packed {
        logic             we;
        logic [QID_W-1:0] waddr;
        desc_t            wdata;
        logic             re;
        logic [QID_W-1:0] raddr;
    } desc_req_t;

    typedef struct packed {
        logic                    we;
        logic [SLOT_AW-1:0]      waddr;
        logic [PAYLOAD_BITS-1:0] wdata;
        logic                    re;
        logic [SLOT_AW-1:0]      raddr;
    } slot_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DESC,
        ST_POP_RD,
        ST_POP_WAIT,
        ST_RESULT
    } state_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [COUNT_W-1:0] sat_count(input logic [FILL_W-1:0] v);
        return (32'(v) > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(v);
    endfunction

    function automatic logic [SLOT_AW-1:0] slot_addr(input logic [QID_W-1:0] q,
                                                     input logic [PTR_W-1:0] p);
        return SLOT_AW'(32'(q) * QUEUE_DEPTH + 32'(p));
    endfunction

endpackage

// ----- sv/mqm_ram.sv -----
module mqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/mqm_ctrl.sv -----
module mqm_ctrl
    import mqm_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    // request side
    input  logic                    in_valid,
    output logic                    in_ready,
    input  cmd_t                    in_cmd,
    input  logic [TARGET_W-1:0]     in_target,
    input  logic [WORD_W-1:0]       in_word,
    input  logic [MAXC_W-1:0]       in_maxc,
    // result side
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [COUNT_W-1:0]      out_count,
    output logic                    out_has,
    output logic [WORD_W-1:0]       out_word,
    output logic                    out_last,
    // memories
    output desc_req_t               desc_req,
    input  logic [DESC_W-1:0]       desc_rdata,
    output slot_req_t               slot_req,
    input  logic [PAYLOAD_BITS-1:0] slot_rdata
);

    state_t state_reg, state_next;

    cmd_t                  cmd_reg;
    logic [QID_W-1:0]      qid_reg;
    logic                  qok_reg;
    logic                  bcast_reg;
    logic [WORD_W-1:0]     word_reg;
    logic [MAXC_W-1:0]     maxc_reg;
    logic [PTR_W-1:0]      ptr_reg;
    logic [COUNT_W-1:0]    remain_reg;
    logic [COUNT_W-1:0]    cnt_reg;
    logic                  dvalid_reg;
    logic [QUEUE_COUNT-1:0] valid_reg;

    logic                  out_valid_reg;
    logic [COUNT_W-1:0]    out_count_reg;
    logic                  out_has_reg;
    logic [WORD_W-1:0]     out_word_reg;
    logic                  out_last_reg;

    logic                  accept;
    logic                  out_free;
    logic                  in_bcast;
    logic                  in_qok;
    logic [TARGET_W+QID_W-1:0] in_tgt_ext;
    logic [QID_W-1:0]      in_qid;
    desc_t                 d;
    logic [COUNT_W-1:0]    lim;
    logic [COUNT_W-1:0]    n;
    logic [31:0]           head_sum;
    logic                  store_ok;
    logic                  bcast_more;
    logic                  load_res;
    logic                  load_pop;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    // request decode, targets past the self queue look at queue zero
    assign in_bcast   = (32'(in_target) >= QUEUE_COUNT) && (in_cmd == CMD_SEND);
    assign in_qok     = (32'(in_target) < QUEUE_COUNT) || in_bcast;
    assign in_tgt_ext = {{QID_W{1'b0}}, in_target};
    assign in_qid     = (32'(in_target) < QUEUE_COUNT) ? in_tgt_ext[QID_W-1:0] : '0;

    // descriptor as read, never-written queues read as empty
    assign d = dvalid_reg ? desc_t'(desc_rdata) : '0;

    assign lim = (32'(maxc_reg) > MAX_POP) ? COUNT_W'(MAX_POP) : maxc_reg;
    always_comb begin
        if (!qok_reg) begin
            n = '0;
        end else if (32'(d.fill) < 32'(lim)) begin
            n = COUNT_W'(d.fill);
        end else begin
            n = lim;
        end
    end

    assign head_sum   = 32'(d.head) + 32'(n);
    assign store_ok   = (cmd_reg == CMD_SEND) && qok_reg && (32'(d.fill) < QUEUE_DEPTH);
    assign bcast_more = (cmd_reg == CMD_SEND) && bcast_reg
                        && (32'(qid_reg) < REGION_COUNT - 1);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_DESC;
                end
            end
            ST_DESC: begin
                priority if (bcast_more) begin
                    state_next = ST_DESC;
                end else if ((cmd_reg == CMD_RECV) && (n != '0)) begin
                    state_next = ST_POP_RD;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_POP_RD: begin
                state_next = ST_POP_WAIT;
            end
            ST_POP_WAIT: begin
                if (out_free) begin
                    state_next = (remain_reg == '0) ? ST_IDLE : ST_POP_RD;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // memory requests and load strobes
    always_comb begin
        desc_req = '0;
        slot_req = '0;
        load_res = 1'b0;
        load_pop = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                desc_req.re    = in_valid;
                desc_req.raddr = in_qid;
            end
            ST_DESC: begin
                desc_req.waddr = qid_reg;
                desc_req.raddr = qid_reg + QID_W'(1);
                desc_req.re    = bcast_more;
                if (store_ok) begin
                    desc_req.we         = 1'b1;
                    desc_req.wdata.head = d.head;
                    desc_req.wdata.tail = ptr_inc(d.tail);
                    desc_req.wdata.fill = d.fill + FILL_W'(1);
                    slot_req.we         = 1'b1;
                    slot_req.waddr      = slot_addr(qid_reg, d.tail);
                    slot_req.wdata      = word_reg[PAYLOAD_BITS-1:0];
                end else if ((cmd_reg == CMD_RECV) && (n != '0)) begin
                    desc_req.we         = 1'b1;
                    desc_req.wdata.head = (head_sum >= QUEUE_DEPTH)
                                          ? PTR_W'(head_sum - QUEUE_DEPTH)
                                          : PTR_W'(head_sum);
                    desc_req.wdata.tail = d.tail;
                    desc_req.wdata.fill = FILL_W'(32'(d.fill) - 32'(n));
                end
            end
            ST_POP_RD: begin
                slot_req.re    = 1'b1;
                slot_req.raddr = slot_addr(qid_reg, ptr_reg);
            end
            ST_POP_WAIT: begin
                load_pop = out_free;
            end
            ST_RESULT: begin
                load_res = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            dvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (desc_req.re) begin
                dvalid_reg <= valid_reg[desc_req.raddr];
            end
            if (desc_req.we) begin
                valid_reg[desc_req.waddr] <= 1'b1;
            end
            if (load_res || load_pop) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg   <= in_cmd;
            qid_reg   <= in_qid;
            qok_reg   <= in_qok;
            bcast_reg <= in_bcast;
            word_reg  <= in_word;
            maxc_reg  <= in_maxc;
            cnt_reg   <= '0;
        end
        if (state_reg == ST_DESC) begin
            unique case (cmd_reg)
                CMD_SEND: begin
                    if (store_ok && (32'(cnt_reg) < COUNT_MAX)) begin
                        cnt_reg <= cnt_reg + COUNT_W'(1);
                    end
                end
                CMD_RECV: begin
                    cnt_reg    <= n;
                    remain_reg <= n;
                    ptr_reg    <= d.head;
                end
                CMD_QUERY: begin
                    cnt_reg <= qok_reg ? sat_count(d.fill) : '0;
                end
                CMD_NONE: begin
                    cnt_reg <= '0;
                end
                default: ;
            endcase
            if (bcast_more) begin
                qid_reg <= qid_reg + QID_W'(1);
            end
        end
        if (state_reg == ST_POP_RD) begin
            ptr_reg    <= ptr_inc(ptr_reg);
            remain_reg <= remain_reg - COUNT_W'(1);
        end
        if (load_res) begin
            out_count_reg <= cnt_reg;
            out_has_reg   <= 1'b0;
            out_word_reg  <= '0;
            out_last_reg  <= 1'b1;
        end else if (load_pop) begin
            out_count_reg <= cnt_reg;
            out_has_reg   <= 1'b1;
            out_word_reg  <= WORD_W'(slot_rdata);
            out_last_reg  <= (remain_reg == '0);
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_count = out_count_reg;
    assign out_has   = out_has_reg;
    assign out_word  = out_word_reg;
    assign out_last  = out_last_reg;

endmodule

// ----- sv/multi_queue_mailbox.sv -----
// multi_queue_mailbox: ring-buffer mailbox with one queue per region plus a self queue
//
// input channel (s_): one request word per handshake; s_tuser carries the command
// (send, receive, occupancy query), s_tdata the target queue, the signal word and
// the receive limit. a send to a target above the self queue is a broadcast to all
// region queues that have room. full queues drop the word without notice.
// result channel (m_): a send or a query gives one word with m_tlast set; a receive
// gives one word per popped entry, m_tlast on the final one, or one empty word.
// timing: the idle state takes a request and issues its queue descriptor read; the
// descriptor state applies and writes back the descriptor, and the result state loads
// a single result into the output register. a broadcast repeats the descriptor state
// per region queue beyond the first. a receive spends a read state and a wait state
// per popped entry on the slot memory (read, then load the output register).
// the output register holds a result while m_tready is low; the sequencer waits
// and a new request is taken once the previous one has loaded its last word.
// reset: every queue starts empty through per-queue valid bits on the descriptor
// memory, so no clearing pass is needed; the slot memory is never read unwritten.
module multi_queue_mailbox
    import mqm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // target, signal_word, max_count, zero pad
    input  logic [CMD_W-1:0]     s_tuser,  // cmd
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // count, popped_word, zero pad
    output logic [0:0]           m_tuser,  // has_item
    output logic                 m_tlast   // last
);

    desc_req_t               desc_req;
    logic [DESC_W-1:0]       desc_rdata;
    slot_req_t               slot_req;
    logic [PAYLOAD_BITS-1:0] slot_rdata;

    logic [COUNT_W-1:0] res_count;
    logic               res_has;
    logic [WORD_W-1:0]  res_word;

    // unpack request fields
    logic [TARGET_W-1:0] req_target;
    logic [WORD_W-1:0]   req_word;
    logic [MAXC_W-1:0]   req_maxc;

    assign req_target = s_tdata[TARGET_W-1:0];
    assign req_word   = s_tdata[TARGET_W +: WORD_W];
    assign req_maxc   = s_tdata[TARGET_W + WORD_W +: MAXC_W];

    mqm_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (cmd_t'(s_tuser)),
        .in_target  (req_target),
        .in_word    (req_word),
        .in_maxc    (req_maxc),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_count  (res_count),
        .out_has    (res_has),
        .out_word   (res_word),
        .out_last   (m_tlast),
        .desc_req   (desc_req),
        .desc_rdata (desc_rdata),
        .slot_req   (slot_req),
        .slot_rdata (slot_rdata)
    );

    // head, tail and fill count for each queue
    mqm_ram #(
        .WIDTH (DESC_W),
        .DEPTH (QUEUE_COUNT)
    ) u_desc_ram (
        .aclk  (aclk),
        .we    (desc_req.we),
        .waddr (desc_req.waddr),
        .wdata (desc_req.wdata),
        .re    (desc_req.re),
        .raddr (desc_req.raddr),
        .rdata (desc_rdata)
    );

    // payload slots, queue-major
    mqm_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (SLOT_DEPTH)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (slot_req.we),
        .waddr (slot_req.waddr),
        .wdata (slot_req.wdata),
        .re    (slot_req.re),
        .raddr (slot_req.raddr),
        .rdata (slot_rdata)
    );

    // pack result word
    assign m_tdata    = M_TDATA_W'({res_word, res_count});
    assign m_tuser[0] = res_has;

    // a word without a popped entry carries a zero payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[COUNT_W +: WORD_W] == '0)
        else $error("payload not zero on a word without entry");

    // send, query and empty receive results are single words
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("non-pop result without last mark");

    // a popped entry always reports a nonzero pop count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[COUNT_W-1:0] != '0)
        else $error("popped entry with zero count");

    // a new request is only taken when the sequencer has finished the previous one
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

endmodule
